// ===== hdl/dqle_pkg.sv =====
package dqle_pkg;

  localparam logic [7:0] DOT_CHAR = 8'h2E;
  localparam logic [7:0] TERM_BYTE = 8'h00;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LEN,
    S_DATA,
    S_TERM
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic store_char;
    logic mark_full;
    logic clear_full;
    logic mark_ovf;
    logic clear_name;
    logic emit_len;
    logic emit_data;
    logic emit_term;
    logic last_data;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_dot;
    logic full;
    logic count_zero;
    logic will_fill;
    logic data_last;
    logic slot_free;
  } status_t;

endpackage

// ===== hdl/dqle_ctrl.sv =====
module dqle_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_end_of_name,
  input  dqle_pkg::status_t status,
  output dqle_pkg::cmd_t    cmd
);

  dqle_pkg::state_t state_r, state_nxt;
  logic term_pend_r, term_pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dqle_pkg::S_IDLE;
      term_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      term_pend_r <= term_pend_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    term_pend_nxt = term_pend_r;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      dqle_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_end_of_name) begin
            if (status.count_zero) begin
              state_nxt = dqle_pkg::S_TERM;
            end else begin
              term_pend_nxt = 1'b1;
              state_nxt     = dqle_pkg::S_LEN;
            end
          end else if (status.is_dot) begin
            cmd.clear_full = 1'b1;
            if (!status.count_zero) begin
              term_pend_nxt = 1'b0;
              state_nxt     = dqle_pkg::S_LEN;
            end
          end else if (status.full) begin
            cmd.mark_ovf = 1'b1;
          end else begin
            cmd.store_char = 1'b1;
            if (status.will_fill) begin
              // label hit the limit: flush now
              cmd.mark_full = 1'b1;
              term_pend_nxt = 1'b0;
              state_nxt     = dqle_pkg::S_LEN;
            end
          end
        end
      end
      dqle_pkg::S_LEN: begin
        if (status.slot_free) begin
          cmd.emit_len = 1'b1;
          state_nxt    = dqle_pkg::S_DATA;
        end
      end
      dqle_pkg::S_DATA: begin
        if (status.slot_free) begin
          cmd.emit_data = 1'b1;
          cmd.last_data = status.data_last && !term_pend_r;
          if (status.data_last) begin
            state_nxt = term_pend_r ? dqle_pkg::S_TERM : dqle_pkg::S_IDLE;
          end
        end
      end
      dqle_pkg::S_TERM: begin
        if (status.slot_free) begin
          cmd.emit_term  = 1'b1;
          cmd.clear_name = 1'b1;
          term_pend_nxt  = 1'b0;
          state_nxt      = dqle_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = dqle_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/dqle_dp.sv =====
module dqle_dp #(
  parameter int MAX_LABEL = 63
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_name_char,
  input  dqle_pkg::cmd_t    cmd,
  output dqle_pkg::status_t status,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last_in_run,
  output logic              out_name_done,
  output logic              out_label_error
);

  localparam int CW = $clog2(MAX_LABEL + 1);
  localparam int AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

  logic [7:0]    mem [0:MAX_LABEL-1];
  logic [7:0]    rdata_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          full_r, full_nxt;
  logic          ovf_r, ovf_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_done_r, out_done_nxt;
  logic          out_err_r, out_err_nxt;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  assign status.is_dot     = (in_name_char == dqle_pkg::DOT_CHAR);
  assign status.full       = full_r;
  assign status.count_zero = (count_r == '0);
  assign status.will_fill  = (count_r == CW'(MAX_LABEL - 1));
  assign status.data_last  = (idx_r == count_r);
  assign status.slot_free  = !out_valid_r || out_ready;

  // label store, single write and registered read
  always_ff @(posedge clk) begin
    if (cmd.store_char) begin
      mem[count_r[AW-1:0]] <= in_name_char;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // prefetch the next character as each byte leaves
  always_comb begin
    rd_en   = cmd.emit_len || (cmd.emit_data && (idx_r < count_r));
    rd_addr = cmd.emit_len ? '0 : idx_r[AW-1:0];
  end

  always_comb begin
    count_nxt = count_r;
    idx_nxt   = idx_r;
    full_nxt  = full_r;
    ovf_nxt   = ovf_r;
    if (cmd.store_char) count_nxt = count_r + CW'(1);
    if (cmd.emit_len)   idx_nxt   = CW'(1);
    if (cmd.emit_data) begin
      idx_nxt = idx_r + CW'(1);
      if (status.data_last) count_nxt = '0;
    end
    if (cmd.mark_full)  full_nxt = 1'b1;
    if (cmd.clear_full) full_nxt = 1'b0;
    if (cmd.mark_ovf)   ovf_nxt  = 1'b1;
    if (cmd.clear_name) begin
      count_nxt = '0;
      full_nxt  = 1'b0;
      ovf_nxt   = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;
    out_err_nxt   = out_err_r;
    if (cmd.emit_len) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = 8'(count_r);
      out_last_nxt  = 1'b0;
      out_done_nxt  = 1'b0;
      out_err_nxt   = 1'b0;
    end else if (cmd.emit_data) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = rdata_r;
      out_last_nxt  = cmd.last_data;
      out_done_nxt  = 1'b0;
      out_err_nxt   = 1'b0;
    end else if (cmd.emit_term) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = dqle_pkg::TERM_BYTE;
      out_last_nxt  = 1'b1;
      out_done_nxt  = 1'b1;
      out_err_nxt   = ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      full_r      <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      full_r      <= full_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_done_r <= out_done_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_in_run = out_last_r;
  assign out_name_done   = out_done_r;
  assign out_label_error = out_err_r;

endmodule

// ===== hdl/dns_qname_label_encoder_core.sv =====
// DNS name encoder: host name characters go in one per transfer and wire-format
// name bytes come out (length byte, label characters, zero terminator). A
// character that only joins the pending label is taken at once. While a label
// (and the terminator on end of name) is flushed, in_ready is low, since the
// label memory has one read port and the output register moves one byte per
// cycle while out_ready is high. Labels reaching MAX_LABEL characters are flushed
// at once; extra characters before the next dot are dropped and flagged by
// out_label_error on the terminator. Empty labels produce no bytes.
module dns_qname_label_encoder_core #(
  parameter int MAX_LABEL = 63
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_name_char,
  input  logic       in_end_of_name,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last_in_run,
  output logic       out_name_done,
  output logic       out_label_error
);

  dqle_pkg::cmd_t    cmd;
  dqle_pkg::status_t status;

  dqle_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_end_of_name (in_end_of_name),
    .status         (status),
    .cmd            (cmd)
  );

  dqle_dp #(
    .MAX_LABEL (MAX_LABEL)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_name_char    (in_name_char),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_in_run (out_last_in_run),
    .out_name_done   (out_name_done),
    .out_label_error (out_label_error)
  );

endmodule

// ===== verif/dqle_wire_scoreboard.sv =====
`timescale 1ns / 1ps

module dqle_wire_scoreboard #(
  parameter int LABEL_LIMIT = 63
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_name_char,
  input  logic       in_end_of_name,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       out_last_in_run,
  input  logic       out_name_done,
  input  logic       out_label_error,
  output int         fail_count,
  output int         pending_bytes
);

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       done;
    logic       err;
  } wire_byte_t;

  logic [7:0] label_buf [LABEL_LIMIT];
  int         label_len;
  logic       label_capped;
  logic       overlong_seen;
  wire_byte_t wire_q [$];
  wire_byte_t burst_q [$];
  wire_byte_t got_byte;
  wire_byte_t want_byte;

  task automatic queue_byte(input logic [7:0] value, input logic done, input logic err);
    wire_byte_t b;
    b.value = value;
    b.last = 1'b0;
    b.done = done;
    b.err = err;
    burst_q.push_back(b);
  endtask

  task automatic flush_label();
    int i;
    if (label_len == 0) return;
    queue_byte(8'(label_len), 1'b0, 1'b0);
    for (i = 0; i < label_len; i++) queue_byte(label_buf[i], 1'b0, 1'b0);
    label_len = 0;
  endtask

  // expected wire bytes for one accepted character or end of name
  task automatic encode_item(input logic [7:0] ch, input logic end_of_name);
    wire_byte_t b;
    burst_q.delete();
    if (end_of_name) begin
      flush_label();
      queue_byte(dqle_pkg::TERM_BYTE, 1'b1, overlong_seen);
      label_capped = 1'b0;
      overlong_seen = 1'b0;
    end else if (ch == dqle_pkg::DOT_CHAR) begin
      flush_label();
      label_capped = 1'b0;
    end else if (label_capped) begin
      // label already flushed at the limit, character is dropped
      overlong_seen = 1'b1;
    end else begin
      label_buf[label_len] = ch;
      label_len++;
      if (label_len >= LABEL_LIMIT) begin
        flush_label();
        label_capped = 1'b1;
      end
    end
    if (burst_q.size() > 0) begin
      b = burst_q.pop_back();
      b.last = 1'b1;
      burst_q.push_back(b);
    end
    while (burst_q.size() > 0) wire_q.push_back(burst_q.pop_front());
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      label_len = 0;
      label_capped = 1'b0;
      overlong_seen = 1'b0;
      wire_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        got_byte = {out_byte, out_last_in_run, out_name_done, out_label_error};
        if (wire_q.size() == 0) begin
          $display("%0t: expected no transfer, got byte %h last %b done %b err %b",
                   $time, got_byte.value, got_byte.last, got_byte.done, got_byte.err);
          fail_count++;
        end else begin
          want_byte = wire_q.pop_front();
          if (got_byte !== want_byte) begin
            $display("%0t: expected %h/%b/%b/%b got %h/%b/%b/%b (byte/last/done/err)",
                     $time, want_byte.value, want_byte.last, want_byte.done, want_byte.err,
                     got_byte.value, got_byte.last, got_byte.done, got_byte.err);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) encode_item(in_name_char, in_end_of_name);
    end
    pending_bytes = wire_q.size();
  end

endmodule

// ===== verif/dns_qname_label_encoder_core_tb.sv =====
`timescale 1ns / 1ps

module dns_qname_label_encoder_core_tb;

  localparam int RANDOM_ITEMS = 370;
  localparam int DRAIN_CYCLES = 70;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_name_char = 8'h00;
  logic       in_end_of_name = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_last_in_run;
  logic       out_name_done;
  logic       out_label_error;

  int   fail_count;
  int   pending_bytes;
  int   sent_items = 0;
  int   rx_cycle = 0;
  logic sender_idles = 1'b1;
  logic random_phase = 1'b0;

  always #4 clk = ~clk;

  dns_qname_label_encoder_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_name_char    (in_name_char),
    .in_end_of_name  (in_end_of_name),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_in_run (out_last_in_run),
    .out_name_done   (out_name_done),
    .out_label_error (out_label_error)
  );

  dqle_wire_scoreboard u_wire_sb (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_name_char    (in_name_char),
    .in_end_of_name  (in_end_of_name),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_in_run (out_last_in_run),
    .out_name_done   (out_name_done),
    .out_label_error (out_label_error),
    .fail_count      (fail_count),
    .pending_bytes   (pending_bytes)
  );

  // receiver: random back-pressure, one long hold-off, one stretch always ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (random_phase) rx_cycle <= rx_cycle + 1;
      if (random_phase && rx_cycle >= 60 && rx_cycle < 260) out_ready <= 1'b0;
      else if (random_phase && rx_cycle >= 700 && rx_cycle < 1000) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 99) >= 20);
    end
  end

  // called at a rising edge, returns at the edge of the transfer
  task automatic send_item(input logic [7:0] ch, input logic end_of_name);
    while (sender_idles && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_name_char <= ch;
    in_end_of_name <= end_of_name;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    sent_items++;
  endtask

  function automatic logic [7:0] label_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == dqle_pkg::DOT_CHAR);
    return c;
  endfunction

  // well-formed name with random content; first_len forces the first label length
  task automatic send_name(input int first_len);
    int k;
    int n_labels;
    int len;
    int r;
    if ($urandom_range(0, 9) == 0) send_item(dqle_pkg::DOT_CHAR, 1'b0);
    n_labels = $urandom_range(1, 4);
    for (k = 0; k < n_labels; k++) begin
      if (k > 0) begin
        repeat (($urandom_range(0, 4) == 0) ? 2 : 1) send_item(dqle_pkg::DOT_CHAR, 1'b0);
      end
      r = $urandom_range(0, 99);
      if (k == 0 && first_len > 0) len = first_len;
      else if (r < 75) len = $urandom_range(1, 6);
      else if (r < 96) len = $urandom_range(7, 20);
      else len = $urandom_range(60, 66);
      repeat (len) send_item(label_char(), 1'b0);
    end
    if ($urandom_range(0, 9) == 0) send_item(dqle_pkg::DOT_CHAR, 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_noise();
    int r;
    repeat ($urandom_range(1, 8)) begin
      r = $urandom_range(0, 99);
      if (r < 10) send_item(8'($urandom_range(0, 255)), 1'b1);
      else if (r < 35) send_item(dqle_pkg::DOT_CHAR, 1'b0);
      else send_item(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  initial begin
    int directed_items;
    int name_idx;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty name, end item carries a character that must be ignored
    send_item(8'hFF, 1'b1);
    send_item(dqle_pkg::DOT_CHAR, 1'b0);
    send_item(8'h00, 1'b1);
    // leading, repeated and trailing dots
    send_item(dqle_pkg::DOT_CHAR, 1'b0);
    send_item(dqle_pkg::DOT_CHAR, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(dqle_pkg::DOT_CHAR, 1'b0);
    send_item(dqle_pkg::DOT_CHAR, 1'b0);
    send_item(8'h00, 1'b1);
    // zero and all-ones characters, neighbors of the dot code
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h2D, 1'b0);
    send_item(8'h2F, 1'b0);
    send_item(8'h55, 1'b1);
    // dot on the end item is not a separator
    send_item(8'h78, 1'b0);
    send_item(8'h79, 1'b0);
    send_item(dqle_pkg::DOT_CHAR, 1'b1);
    send_item(8'h80, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(dqle_pkg::DOT_CHAR, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'hAA, 1'b1);
    directed_items = sent_items;

    random_phase <= 1'b1;
    name_idx = 0;
    while (sent_items - directed_items < RANDOM_ITEMS) begin
      sender_idles = !(name_idx >= 12 && name_idx < 22);
      // first names hit the label limit exactly and then run past it
      if (name_idx == 0) send_name(63);
      else if (name_idx == 1) send_name(66);
      else if ($urandom_range(0, 99) < 80) send_name(0);
      else send_noise();
      name_idx++;
    end
    in_valid <= 1'b0;

    @(negedge clk);
    while (pending_bytes != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
